// ===== hdl/sdspi_pkg.sv =====
`default_nettype none
package sdspi_pkg;

  localparam int unsigned NumCfgRegs = 5;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RESPONSE_RETRIES    = 3'd0,
    CFG_INIT_CLOCK_BYTES    = 3'd1,
    CFG_READ_PREAMBLE_BYTES = 3'd2,
    CFG_OP_COND_LIMIT       = 3'd3,
    CFG_TOKEN_LIMIT         = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_EXCHANGE   = 2'd0,
    OP_START_INIT = 2'd1,
    OP_START_READ = 2'd2,
    OP_RESERVED   = 2'd3
  } op_t;

  typedef enum logic [10:0] {
    PH_IDLE  = 11'b00000000001,
    PH_CLK   = 11'b00000000010,
    PH_CMD   = 11'b00000000100,
    PH_POLL  = 11'b00000001000,
    PH_RESP  = 11'b00000010000,
    PH_TAIL  = 11'b00000100000,
    PH_PRE   = 11'b00001000000,
    PH_TOKEN = 11'b00010000000,
    PH_DATA  = 11'b00100000000,
    PH_CRC   = 11'b01000000000,
    PH_RTAIL = 11'b10000000000
  } phase_t;

  typedef enum logic [2:0] {
    K_CMD0   = 3'd0,
    K_CMD8   = 3'd1,
    K_CMD55  = 3'd2,
    K_ACMD41 = 3'd3,
    K_CMD58  = 3'd4,
    K_CMD16  = 3'd5,
    K_CMD17  = 3'd6
  } sd_cmd_t;

  typedef enum logic [3:0] {
    ST_OK            = 4'd0,
    ST_CMD0          = 4'd1,
    ST_ILLEGAL_CMD8  = 4'd2,
    ST_CMD8          = 4'd3,
    ST_ECHO          = 4'd4,
    ST_CMD55         = 4'd5,
    ST_ACMD41_TMO    = 4'd6,
    ST_CMD58         = 4'd7,
    ST_CMD16         = 4'd8,
    ST_CMD17         = 4'd9,
    ST_TOKEN_TMO     = 4'd10
  } status_t;

  localparam logic [7:0]  FILL_BYTE   = 8'hFF;
  localparam logic [7:0]  START_TOKEN = 8'hFE;
  localparam logic [7:0]  R1_IDLE     = 8'h01;
  localparam logic [7:0]  R1_ILLEGAL  = 8'h05;
  localparam logic [7:0]  ECHO_PATT   = 8'hAA;
  localparam logic [31:0] ARG_CMD8    = 32'h0000_01AA;
  localparam logic [31:0] ARG_ACMD41  = 32'h4000_0000;
  localparam logic [2:0]  FRAME_LAST  = 3'd5;

  typedef struct packed {
    logic [3:0]  response_retries;
    logic [7:0]  init_clock_bytes;
    logic [7:0]  read_preamble_bytes;
    logic [15:0] op_cond_limit;
    logic [23:0] token_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] blk_addr;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        chip_select;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic        data_last;
    logic        done_res;
    logic [3:0]  status;
    logic [31:0] ocr;
  } result_t;

  function automatic logic [7:0] cmd_code(input sd_cmd_t k);
    case (k)
      K_CMD0:   cmd_code = 8'd0;
      K_CMD8:   cmd_code = 8'd8;
      K_CMD55:  cmd_code = 8'd55;
      K_ACMD41: cmd_code = 8'd41;
      K_CMD58:  cmd_code = 8'd58;
      K_CMD16:  cmd_code = 8'd16;
      K_CMD17:  cmd_code = 8'd17;
      default:  cmd_code = 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] cmd_crc(input sd_cmd_t k);
    case (k)
      K_CMD0:  cmd_crc = 8'h95;
      K_CMD8:  cmd_crc = 8'h87;
      default: cmd_crc = 8'hFF;
    endcase
  endfunction

  function automatic logic [2:0] cmd_len(input sd_cmd_t k);
    case (k)
      K_CMD8, K_CMD58: cmd_len = 3'd5;
      default:         cmd_len = 3'd1;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== hdl/sdspi_if.sv =====
`default_nettype none
interface sdspi_in_if import sdspi_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sdspi_out_if import sdspi_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sdspi_cfg_if import sdspi_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [31:0]        wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

// ===== hdl/sd_spi_init_and_block_read.sv =====
// SPI-mode SD card sequencer. Send command 1 (init) or 2 (block read with blk_addr),
// then feed back each received byte with command 0; every beat in gives one beat out
// holding the next byte to send and its chip select, any block data byte, and a done
// flag with status at the end. One beat per clock is sustained while out_ch.ready holds;
// each beat passes through the input register, then the registered result.
// A start command aborts any running sequence.
`default_nettype none
module sd_spi_init_and_block_read import sdspi_pkg::*; #(
  parameter int unsigned BLOCK_BYTES = 512
) (
  input  wire         clk,
  input  wire         rst_n,
  sdspi_in_if.sink    in_ch,
  sdspi_out_if.source out_ch,
  sdspi_cfg_if.sink   cfg_ch
);

  cfg_t    regs;
  logic    step;
  item_t   item;
  result_t res;

  sdspi_cfg_regs u_cfg (.clk(clk), .rst_n(rst_n), .cfg(cfg_ch), .regs(regs));

  sdspi_io_regs u_io (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .step(step), .item(item), .res(res)
  );

  sdspi_seq #(.BLOCK_BYTES(BLOCK_BYTES)) u_seq (
    .clk(clk), .rst_n(rst_n), .step(step), .item(item), .cfg(regs), .res(res)
  );

endmodule
`default_nettype wire

// ===== hdl/sdspi_cfg_regs.sv =====
`default_nettype none
module sdspi_cfg_regs import sdspi_pkg::*; (
  input  wire       clk,
  input  wire       rst_n,
  sdspi_cfg_if.sink cfg,
  output cfg_t      regs
);

  cfg_t regs_r;

  assign cfg.ready = 1'b1;
  assign regs = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.response_retries    <= 4'd8;
      regs_r.init_clock_bytes    <= 8'd10;
      regs_r.read_preamble_bytes <= 8'd10;
      regs_r.op_cond_limit       <= 16'd50000;
      regs_r.token_limit         <= 24'd1000000;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_RESPONSE_RETRIES:    regs_r.response_retries    <= cfg.wdata[3:0];
        CFG_INIT_CLOCK_BYTES:    regs_r.init_clock_bytes    <= cfg.wdata[7:0];
        CFG_READ_PREAMBLE_BYTES: regs_r.read_preamble_bytes <= cfg.wdata[7:0];
        CFG_OP_COND_LIMIT:       regs_r.op_cond_limit       <= cfg.wdata[15:0];
        CFG_TOKEN_LIMIT:         regs_r.token_limit         <= cfg.wdata[23:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sdspi_seq.sv =====
`default_nettype none
module sdspi_seq import sdspi_pkg::*; #(
  parameter int unsigned BLOCK_BYTES = 512
) (
  input  wire     clk,
  input  wire     rst_n,
  input  wire     step,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  localparam int unsigned CntW = $clog2(BLOCK_BYTES + 1);
  localparam logic [CntW-1:0] LastIdx = CntW'(BLOCK_BYTES - 1);

  phase_t        phase_r, phase_nxt;
  logic [CntW-1:0] byte_count_r, byte_count_nxt, bc_inc;
  logic [3:0]    retry_count_r, retry_count_nxt, retry_lim;
  logic [15:0]   opcond_count_r, opcond_count_nxt;
  logic [23:0]   token_count_r, token_count_nxt;
  logic [31:0]   arg_r, arg_nxt;
  logic [31:0]   ocr_r, ocr_nxt;
  logic [2:0]    rindex_r, rindex_nxt;
  logic          echo_ok_r, echo_ok_nxt;
  sd_cmd_t       cur_cmd_r, cur_cmd_nxt;
  logic [7:0]    last_r1_r, last_r1_nxt;
  result_t       o;
  logic [7:0]    rx;
  op_t           op;

  function automatic logic [7:0] frame_byte(input sd_cmd_t k, input logic [31:0] a,
                                            input logic [2:0] i);
    case (i)
      3'd0:    frame_byte = 8'h40 | cmd_code(k);
      3'd1:    frame_byte = a[31:24];
      3'd2:    frame_byte = a[23:16];
      3'd3:    frame_byte = a[15:8];
      3'd4:    frame_byte = a[7:0];
      default: frame_byte = cmd_crc(k);
    endcase
  endfunction

  assign rx = item.rx_byte;
  assign op = op_t'(item.command);
  assign bc_inc = byte_count_r + 1'b1;
  assign retry_lim = (cfg.response_retries == 4'd0) ? 4'd1 : cfg.response_retries;

  always_comb begin
    logic [15:0] opc;
    logic [23:0] tok;
    logic [2:0]  ri;
    logic        do_start, do_after;
    sd_cmd_t     start_k;
    phase_nxt = phase_r;
    byte_count_nxt = byte_count_r;
    retry_count_nxt = retry_count_r;
    opcond_count_nxt = opcond_count_r;
    token_count_nxt = token_count_r;
    arg_nxt = arg_r;
    ocr_nxt = ocr_r;
    rindex_nxt = rindex_r;
    echo_ok_nxt = echo_ok_r;
    cur_cmd_nxt = cur_cmd_r;
    last_r1_nxt = last_r1_r;
    o = '0;
    do_start = 1'b0;
    do_after = 1'b0;
    start_k = K_CMD0;
    opc = opcond_count_r + 16'd1;
    tok = token_count_r + 24'd1;
    ri = rindex_r + 3'd1;

    if (op == OP_START_INIT) begin
      byte_count_nxt = '0;
      if (cfg.init_clock_bytes == 8'd0) begin
        do_start = 1'b1; start_k = K_CMD0;
      end else begin
        phase_nxt = PH_CLK; o.tx_valid = 1'b1; o.tx_byte = FILL_BYTE;
      end
    end else if (op == OP_START_READ) begin
      byte_count_nxt = '0;
      arg_nxt = item.blk_addr;
      cur_cmd_nxt = K_CMD17;
      if (cfg.read_preamble_bytes == 8'd0) begin
        do_start = 1'b1; start_k = K_CMD17;
      end else begin
        phase_nxt = PH_PRE; o.tx_valid = 1'b1; o.tx_byte = FILL_BYTE;
      end
    end else begin
      case (phase_r)
        PH_CLK: begin
          byte_count_nxt = bc_inc;
          if (bc_inc < CntW'(cfg.init_clock_bytes)) begin
            o.tx_valid = 1'b1; o.tx_byte = FILL_BYTE;
          end else begin
            do_start = 1'b1; start_k = K_CMD0;
          end
        end
        PH_PRE: begin
          byte_count_nxt = bc_inc;
          if (bc_inc < CntW'(cfg.read_preamble_bytes)) begin
            o.tx_valid = 1'b1; o.tx_byte = FILL_BYTE;
          end else begin
            do_start = 1'b1; start_k = K_CMD17;
          end
        end
        PH_CMD: begin
          byte_count_nxt = bc_inc;
          o.tx_valid = 1'b1; o.chip_select = 1'b1;
          if (bc_inc < CntW'(6)) begin
            o.tx_byte = frame_byte(cur_cmd_r, arg_r, bc_inc[2:0]);
          end else begin
            phase_nxt = PH_POLL; retry_count_nxt = 4'd0; o.tx_byte = FILL_BYTE;
          end
        end
        PH_POLL: begin
          retry_count_nxt = retry_count_r + 4'd1;
          if (!rx[7] || (retry_count_r + 4'd1) >= retry_lim) begin
            last_r1_nxt = rx;
            rindex_nxt = 3'd1;
            if (cmd_len(cur_cmd_r) > 3'd1) begin
              phase_nxt = PH_RESP;
              o.tx_valid = 1'b1; o.tx_byte = FILL_BYTE; o.chip_select = 1'b1;
            end else begin
              do_after = 1'b1;
            end
          end else begin
            o.tx_valid = 1'b1; o.tx_byte = FILL_BYTE; o.chip_select = 1'b1;
          end
        end
        PH_RESP: begin
          if (cur_cmd_r == K_CMD8) begin
            if (rindex_r == 3'd3 && rx != R1_IDLE) echo_ok_nxt = 1'b0;
            if (rindex_r == 3'd4 && rx != ECHO_PATT) echo_ok_nxt = 1'b0;
          end else if (cur_cmd_r == K_CMD58) begin
            ocr_nxt = {ocr_r[23:0], rx};
          end
          rindex_nxt = ri;
          if (ri >= cmd_len(cur_cmd_r)) begin
            do_after = 1'b1;
          end else begin
            o.tx_valid = 1'b1; o.tx_byte = FILL_BYTE; o.chip_select = 1'b1;
          end
        end
        PH_TAIL: begin
          case (cur_cmd_r)
            K_CMD0: begin
              if (last_r1_r != R1_IDLE) begin
                o.done_res = 1'b1; o.status = ST_CMD0;
              end else begin
                do_start = 1'b1; start_k = K_CMD8;
              end
            end
            K_CMD8: begin
              if (last_r1_r == R1_ILLEGAL) begin
                o.done_res = 1'b1; o.status = ST_ILLEGAL_CMD8;
              end else if (last_r1_r != R1_IDLE) begin
                o.done_res = 1'b1; o.status = ST_CMD8;
              end else if (!echo_ok_r) begin
                o.done_res = 1'b1; o.status = ST_ECHO;
              end else begin
                opcond_count_nxt = 16'd0; do_start = 1'b1; start_k = K_CMD55;
              end
            end
            K_CMD55: begin
              if (last_r1_r > 8'd1) begin
                o.done_res = 1'b1; o.status = ST_CMD55;
              end else begin
                do_start = 1'b1; start_k = K_ACMD41;
              end
            end
            K_ACMD41: begin
              opcond_count_nxt = opc;
              if (cfg.op_cond_limit == 16'd0 || opc >= cfg.op_cond_limit) begin
                o.done_res = 1'b1; o.status = ST_ACMD41_TMO;
              end else if (last_r1_r != 8'd0) begin
                do_start = 1'b1; start_k = K_CMD55;
              end else begin
                do_start = 1'b1; start_k = K_CMD58;
              end
            end
            K_CMD58: begin
              if (last_r1_r != 8'd0) begin
                o.done_res = 1'b1; o.status = ST_CMD58;
              end else begin
                do_start = 1'b1; start_k = K_CMD16;
              end
            end
            K_CMD16: begin
              o.done_res = 1'b1;
              o.status = (last_r1_r != 8'd0) ? ST_CMD16 : ST_OK;
            end
            default: begin
              o.done_res = 1'b1; o.status = ST_OK;
            end
          endcase
          if (o.done_res) phase_nxt = PH_IDLE;
        end
        PH_TOKEN: begin
          token_count_nxt = tok;
          if (cfg.token_limit == 24'd0 || tok >= cfg.token_limit) begin
            phase_nxt = PH_IDLE; o.done_res = 1'b1; o.status = ST_TOKEN_TMO;
          end else begin
            if (rx == START_TOKEN) begin
              phase_nxt = PH_DATA; byte_count_nxt = '0;
            end
            o.tx_valid = 1'b1; o.tx_byte = FILL_BYTE; o.chip_select = 1'b1;
          end
        end
        PH_DATA: begin
          o.data_valid = 1'b1;
          o.data_byte = rx;
          o.data_last = (byte_count_r == LastIdx);
          o.tx_valid = 1'b1; o.tx_byte = FILL_BYTE; o.chip_select = 1'b1;
          if (byte_count_r == LastIdx) begin
            phase_nxt = PH_CRC; byte_count_nxt = '0;
          end else begin
            byte_count_nxt = bc_inc;
          end
        end
        PH_CRC: begin
          byte_count_nxt = bc_inc;
          o.tx_valid = 1'b1; o.tx_byte = FILL_BYTE;
          if (bc_inc < CntW'(2)) begin
            o.chip_select = 1'b1;
          end else begin
            phase_nxt = PH_RTAIL;
          end
        end
        PH_RTAIL: begin
          phase_nxt = PH_IDLE; o.done_res = 1'b1; o.status = ST_OK;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end

    if (do_after) begin
      if (cur_cmd_r == K_CMD17) begin
        if (last_r1_nxt != 8'd0) begin
          phase_nxt = PH_IDLE; o.done_res = 1'b1; o.status = ST_CMD17;
        end else begin
          phase_nxt = PH_TOKEN; token_count_nxt = 24'd0;
          o.tx_valid = 1'b1; o.tx_byte = FILL_BYTE; o.chip_select = 1'b1;
        end
      end else begin
        phase_nxt = PH_TAIL;
        o.tx_valid = 1'b1; o.tx_byte = FILL_BYTE;
      end
    end

    if (do_start) begin
      cur_cmd_nxt = start_k;
      case (start_k)
        K_CMD8:   begin arg_nxt = ARG_CMD8; echo_ok_nxt = 1'b1; end
        K_ACMD41: arg_nxt = ARG_ACMD41;
        K_CMD16:  arg_nxt = 32'(BLOCK_BYTES);
        K_CMD17:  ;
        default:  arg_nxt = 32'd0;
      endcase
      phase_nxt = PH_CMD;
      byte_count_nxt = '0;
      o.tx_valid = 1'b1; o.chip_select = 1'b1;
      o.tx_byte = frame_byte(start_k, arg_nxt, 3'd0);
    end

    o.ocr = ocr_nxt;
  end

  assign res = o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      byte_count_r <= '0;
      retry_count_r <= '0;
      opcond_count_r <= '0;
      token_count_r <= '0;
      arg_r <= '0;
      ocr_r <= '0;
      rindex_r <= '0;
      echo_ok_r <= 1'b1;
      cur_cmd_r <= K_CMD0;
      last_r1_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      byte_count_r <= byte_count_nxt;
      retry_count_r <= retry_count_nxt;
      opcond_count_r <= opcond_count_nxt;
      token_count_r <= token_count_nxt;
      arg_r <= arg_nxt;
      ocr_r <= ocr_nxt;
      rindex_r <= rindex_nxt;
      echo_ok_r <= echo_ok_nxt;
      cur_cmd_r <= cur_cmd_nxt;
      last_r1_r <= last_r1_nxt;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(phase_r))
    else $error("phase not one-hot");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.done_res |=> phase_r == PH_IDLE)
    else $error("done without idle");
  a_done_notx: assert property (@(posedge clk) disable iff (!rst_n)
    res.done_res |-> !res.tx_valid)
    else $error("done with exchange");
  a_data_cs: assert property (@(posedge clk) disable iff (!rst_n)
    res.data_valid |-> res.chip_select && phase_r == PH_DATA)
    else $error("data outside data phase");

endmodule
`default_nettype wire

// ===== hdl/sdspi_io_regs.sv =====
`default_nettype none
module sdspi_io_regs import sdspi_pkg::*; (
  input  wire          clk,
  input  wire          rst_n,
  sdspi_in_if.sink     in_ch,
  sdspi_out_if.source  out_ch,
  output logic         step,
  output item_t        item,
  input  result_t      res
);

  logic    in_valid_r;
  item_t   in_data_r;
  logic    out_valid_r;
  result_t out_data_r;
  logic    move;

  // input stage advances when the result slot is free or draining
  assign move = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || move;
  assign step = move;
  assign item = in_data_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) in_valid_r <= in_ch.valid;
      if (move) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) in_data_r <= in_ch.data;
    if (move) out_data_r <= res;
  end

endmodule
`default_nettype wire
